/* hw/rtl/cspm_pkg.sv */
// ----------------------------------------------------------------------------
// CAN signal plausibility monitor - package
// Shared types, codes and limits for the monitor and its sub-units.
// ----------------------------------------------------------------------------
package cspm_pkg;

  localparam int NUM_ENT = 3;
  localparam int IDX_W   = 2;
  localparam int ID_W    = 11;
  localparam int TMO_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  // item operation
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // entry order
  localparam logic [IDX_W-1:0] ENT_SPD  = 2'd0;
  localparam logic [IDX_W-1:0] ENT_TEMP = 2'd1;
  localparam logic [IDX_W-1:0] ENT_HB   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPD_ID   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_ID  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HB_ID    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPD_TMO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_TMO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HB_TMO   = 3'd5;

  // register reset values
  localparam logic [ID_W-1:0]  RST_SPD_ID   = 11'd256;
  localparam logic [ID_W-1:0]  RST_TEMP_ID  = 11'd257;
  localparam logic [ID_W-1:0]  RST_HB_ID    = 11'd258;
  localparam logic [TMO_W-1:0] RST_SPD_TMO  = 16'd300;
  localparam logic [TMO_W-1:0] RST_TEMP_TMO = 16'd500;
  localparam logic [TMO_W-1:0] RST_HB_TMO   = 16'd1500;

  // event codes
  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_SPD_LEN   = 4'd1;
  localparam logic [3:0] EV_SPD_HIGH  = 4'd2;
  localparam logic [3:0] EV_TEMP_LEN  = 4'd3;
  localparam logic [3:0] EV_TEMP_HIGH = 4'd4;
  localparam logic [3:0] EV_HB_LEN    = 4'd5;
  localparam logic [3:0] EV_HB_BAD    = 4'd6;
  localparam logic [3:0] EV_SPD_TMO   = 4'd7;

  // severities
  localparam logic [1:0] SEV_NONE = 2'd0;
  localparam logic [1:0] SEV_WARN = 2'd1;
  localparam logic [1:0] SEV_ERR  = 2'd2;

  // plausibility limits
  localparam logic [3:0]  SPD_DLC  = 4'd2;
  localparam logic [3:0]  TEMP_DLC = 4'd1;
  localparam logic [3:0]  HB_DLC   = 4'd1;
  localparam logic [15:0] SPD_MAX  = 16'd4000;
  localparam logic [7:0]  TEMP_MAX = 8'd150;
  localparam logic [7:0]  HB_VAL   = 8'hAA;

  typedef struct packed {
    logic        operation;
    logic [10:0] can_id;
    logic [3:0]  data_length;
    logic [7:0]  data_byte0;
    logic [7:0]  data_byte1;
    logic [31:0] time_ms;
  } cspm_in_t;

  typedef struct packed {
    logic        frame_valid;
    logic [3:0]  event_code;
    logic [1:0]  severity;
    logic [15:0] reported_value;
    logic        last;
  } cspm_out_t;

  // entry table write controls
  typedef struct packed {
    logic               stamp_en;
    logic [NUM_ENT-1:0] stamp_mask;
    logic               clr_en;
    logic [IDX_W-1:0]   clr_idx;
  } cspm_tbl_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRAME,
    ST_SCAN,
    ST_EMIT
  } cspm_state_e;

endpackage

/* hw/rtl/cspm_in_if.sv */
// ----------------------------------------------------------------------------
// CAN monitor input channel
// Valid/ready channel carrying one frame or check item per beat.
// ----------------------------------------------------------------------------
interface cspm_in_if import cspm_pkg::*; ();
  logic     valid;
  logic     ready;
  cspm_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/cspm_out_if.sv */
// ----------------------------------------------------------------------------
// CAN monitor result channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface cspm_out_if import cspm_pkg::*; ();
  logic      valid;
  logic      ready;
  cspm_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/can_signal_plausibility_monitor.sv */
// ----------------------------------------------------------------------------
// CAN signal plausibility monitor
// Watches three identifiers for length, value and arrival timeouts.
// ----------------------------------------------------------------------------
// Usage:
//   item_i carries frame items (operation 0) and timeout checks (operation 1).
//   res_o returns results; the last beat of an item has last set.
//   A frame item always gives exactly one result beat. A check gives one
//   beat per entry that has timed out, in the order speed, temperature,
//   heartbeat, and no beat at all when nothing has expired.
//   Sequence: a frame is accepted, then stamped and checked. A check is
//   accepted, then scans the entries one at a time through the shared
//   elapsed-time subtractor, then gives one beat per timeout result.
//   item_i.ready is high only while the sequencer is idle.
//   Results sit in an output register, so a new item is taken while the
//   previous result waits; if res_o stalls, the sequencer holds at its next
//   result until the register frees.
//   Reset: all entries disarmed, identifier and timeout registers return to
//   their defaults; no clearing pass is needed.
//   The user must make configuration writes (cfg_we_i) only while idle; the
//   block does not enforce it; indexes beyond the heartbeat timeout are dropped.
// ----------------------------------------------------------------------------
module can_signal_plausibility_monitor import cspm_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cspm_in_if.sink              item_i,
  cspm_out_if.source           res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENT - 1);

  cspm_state_e state_q, state_d;

  logic [ID_W-1:0]  id_q  [NUM_ENT];
  logic [TMO_W-1:0] tmo_q [NUM_ENT];

  cspm_in_t             item_q;
  logic [TIME_BITS-1:0] now;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [NUM_ENT-1:0]   mask_q, mask_d, mask_nxt;
  logic [NUM_ENT-1:0]   pick, mask_rest;
  logic [IDX_W-1:0]     pick_idx;

  logic      res_vld_q, res_load;
  cspm_out_t res_q, res_d;
  logic      out_free, accept;

  cspm_tbl_wr_t         tbl_wr;
  logic [NUM_ENT-1:0]   armed_w;
  logic [TIME_BITS-1:0] last_rd;
  logic                 tmo_gt, expired;

  logic [NUM_ENT-1:0] chk_match;
  cspm_out_t          chk_res;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q[ENT_SPD]   <= RST_SPD_ID;
      id_q[ENT_TEMP]  <= RST_TEMP_ID;
      id_q[ENT_HB]    <= RST_HB_ID;
      tmo_q[ENT_SPD]  <= RST_SPD_TMO;
      tmo_q[ENT_TEMP] <= RST_TEMP_TMO;
      tmo_q[ENT_HB]   <= RST_HB_TMO;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SPD_ID:   id_q[ENT_SPD]   <= cfg_wdata_i[ID_W-1:0];
        REG_TEMP_ID:  id_q[ENT_TEMP]  <= cfg_wdata_i[ID_W-1:0];
        REG_HB_ID:    id_q[ENT_HB]    <= cfg_wdata_i[ID_W-1:0];
        REG_SPD_TMO:  tmo_q[ENT_SPD]  <= cfg_wdata_i[TMO_W-1:0];
        REG_TEMP_TMO: tmo_q[ENT_TEMP] <= cfg_wdata_i[TMO_W-1:0];
        REG_HB_TMO:   tmo_q[ENT_HB]   <= cfg_wdata_i[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- input latch
  assign accept = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i.data;
    end
  end

  // time is kept modulo 2^TIME_BITS
  assign now = TIME_BITS'(item_q.time_ms);

  // ------------------------------------------------------------ sub-units
  cspm_frame_chk u_chk (
    .ids_i   (id_q),
    .item_i  (item_q),
    .match_o (chk_match),
    .res_o   (chk_res)
  );

  cspm_entry_tbl #(.TIME_BITS(TIME_BITS)) u_tbl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (tbl_wr),
    .stamp_time_i (now),
    .rd_idx_i     (idx_q),
    .armed_o      (armed_w),
    .rd_last_o    (last_rd)
  );

  // one entry per cycle through the shared subtract/compare
  cspm_tmo_unit #(.TIME_BITS(TIME_BITS)) u_tmo (
    .now_i     (now),
    .last_i    (last_rd),
    .limit_i   (tmo_q[idx_q]),
    .expired_o (tmo_gt)
  );

  assign expired  = armed_w[idx_q] && tmo_gt;
  assign mask_nxt = mask_q | (NUM_ENT'(expired) << idx_q);

  // lowest pending timeout goes out first
  assign pick      = mask_q & (~mask_q + NUM_ENT'(1));
  assign mask_rest = mask_q & ~pick;

  always_comb begin
    if (mask_q[ENT_SPD]) begin
      pick_idx = ENT_SPD;
    end else if (mask_q[ENT_TEMP]) begin
      pick_idx = ENT_TEMP;
    end else begin
      pick_idx = ENT_HB;
    end
  end

  assign out_free = !res_vld_q || res_o.ready;

  // ----------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (item_i.data.operation == OP_FRAME) ? ST_FRAME : ST_SCAN;
        end
      end
      ST_FRAME: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (idx_q == LAST_IDX) begin
          state_d = (mask_nxt != '0) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free && (mask_rest == '0)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    item_i.ready = 1'b0;
    tbl_wr       = '0;
    res_load     = 1'b0;
    res_d        = chk_res;
    idx_d        = idx_q;
    mask_d       = mask_q;
    case (state_q)
      ST_IDLE: begin
        item_i.ready = 1'b1;
        idx_d        = '0;
        mask_d       = '0;
      end
      ST_FRAME: begin
        if (out_free) begin
          tbl_wr.stamp_en   = 1'b1;
          tbl_wr.stamp_mask = chk_match;
          res_load          = 1'b1;
        end
      end
      ST_SCAN: begin
        tbl_wr.clr_en  = expired;
        tbl_wr.clr_idx = idx_q;
        idx_d          = idx_q + IDX_W'(1);
        mask_d         = mask_nxt;
      end
      ST_EMIT: begin
        res_d = '{frame_valid: 1'b0, event_code: EV_SPD_TMO + 4'(pick_idx),
                  severity: SEV_ERR, reported_value: 16'd0,
                  last: (mask_rest == '0)};
        if (out_free) begin
          res_load = 1'b1;
          mask_d   = mask_rest;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      mask_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      mask_q  <= mask_d;
      if (res_load) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------- output register
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;

  // ------------------------------------------------------------ assertions
  // a beat that is not last leaves more timeouts pending
  a_more_after_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && !res_o.data.last) |-> (state_q == ST_EMIT))
    else $error("non-final result with no further result pending");

  // no stale timeouts survive into the next item
  a_mask_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (mask_q == '0))
    else $error("pending timeout mask not empty while idle");

  a_scan_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q <= LAST_IDX))
    else $error("scan index beyond last entry");

  // an expired entry is disarmed by the next cycle
  a_disarm_on_expiry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && expired) |=> !armed_w[$past(idx_q)])
    else $error("expired entry still armed");

  a_tmo_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.data.event_code >= EV_SPD_TMO))
      |-> (!res_o.data.frame_valid && (res_o.data.reported_value == 16'd0)))
    else $error("timeout result with frame fields set");

endmodule

/* hw/rtl/cspm_entry_tbl.sv */
// ----------------------------------------------------------------------------
// CAN monitor timeout entry table
// Armed flags and last-seen times of the three monitored identifiers.
// ----------------------------------------------------------------------------
module cspm_entry_tbl import cspm_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cspm_tbl_wr_t         wr_i,
  input  logic [TIME_BITS-1:0] stamp_time_i,
  input  logic [IDX_W-1:0]     rd_idx_i,
  output logic [NUM_ENT-1:0]   armed_o,
  output logic [TIME_BITS-1:0] rd_last_o
);

  logic [NUM_ENT-1:0]   armed_q;
  logic [TIME_BITS-1:0] last_q [NUM_ENT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
    end else begin
      for (int i = 0; i < NUM_ENT; i++) begin
        if (wr_i.stamp_en && wr_i.stamp_mask[i]) begin
          armed_q[i] <= 1'b1;
        end else if (wr_i.clr_en && (wr_i.clr_idx == IDX_W'(i))) begin
          armed_q[i] <= 1'b0;
        end
      end
    end
  end

  // last-seen time is only read once the entry is armed
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_ENT; i++) begin
      if (wr_i.stamp_en && wr_i.stamp_mask[i]) begin
        last_q[i] <= stamp_time_i;
      end
    end
  end

  assign armed_o   = armed_q;
  assign rd_last_o = last_q[rd_idx_i];

endmodule

/* hw/rtl/cspm_tmo_unit.sv */
// ----------------------------------------------------------------------------
// CAN monitor timeout unit
// Shared modular elapsed-time subtractor and limit comparator.
// ----------------------------------------------------------------------------
module cspm_tmo_unit import cspm_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [TIME_BITS-1:0] last_i,
  input  logic [TMO_W-1:0]     limit_i,
  output logic                 expired_o
);

  logic [TIME_BITS-1:0] elapsed;

  // wraps modulo 2^TIME_BITS by construction
  assign elapsed   = now_i - last_i;
  assign expired_o = elapsed > TIME_BITS'(limit_i);

endmodule

/* hw/rtl/cspm_frame_chk.sv */
// ----------------------------------------------------------------------------
// CAN monitor frame checker
// Identifier match, length and value plausibility of one received frame.
// ----------------------------------------------------------------------------
module cspm_frame_chk import cspm_pkg::*; (
  input  logic [ID_W-1:0]    ids_i [NUM_ENT],
  input  cspm_in_t           item_i,
  output logic [NUM_ENT-1:0] match_o,
  output cspm_out_t          res_o
);

  logic [15:0] rpm;
  logic [3:0]  dlc;
  logic [7:0]  b0;

  assign dlc = item_i.data_length;
  assign b0  = item_i.data_byte0;
  assign rpm = {item_i.data_byte1, item_i.data_byte0};

  always_comb begin
    for (int i = 0; i < NUM_ENT; i++) begin
      match_o[i] = (ids_i[i] == item_i.can_id);
    end
  end

  // first match wins: speed, then temperature, then heartbeat
  always_comb begin
    res_o = '{frame_valid: 1'b1, event_code: EV_NONE, severity: SEV_NONE,
              reported_value: 16'd0, last: 1'b1};
    if (match_o[ENT_SPD]) begin
      if (dlc != SPD_DLC) begin
        res_o = '{1'b0, EV_SPD_LEN, SEV_ERR, {12'd0, dlc}, 1'b1};
      end else if (rpm > SPD_MAX) begin
        res_o = '{1'b0, EV_SPD_HIGH, SEV_WARN, rpm, 1'b1};
      end
    end else if (match_o[ENT_TEMP]) begin
      if (dlc != TEMP_DLC) begin
        res_o = '{1'b0, EV_TEMP_LEN, SEV_ERR, {12'd0, dlc}, 1'b1};
      end else if (b0 > TEMP_MAX) begin
        res_o = '{1'b0, EV_TEMP_HIGH, SEV_WARN, {8'd0, b0}, 1'b1};
      end
    end else if (match_o[ENT_HB]) begin
      if (dlc != HB_DLC) begin
        res_o = '{1'b0, EV_HB_LEN, SEV_ERR, {12'd0, dlc}, 1'b1};
      end else if (b0 != HB_VAL) begin
        res_o = '{1'b0, EV_HB_BAD, SEV_ERR, {8'd0, b0}, 1'b1};
      end
    end
  end

endmodule
